### hw/rtl/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;

  localparam int unsigned AdcBits = 10;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgBaseSpeed = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKp = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKd = 2'd2;

  localparam logic OpCalibrate = 1'b0;
  localparam logic OpRun = 1'b1;

  // Width of signed quotient/dividend path in the shared divider.
  localparam int unsigned DivW = 48;

  typedef enum logic [2:0] {
    StIdle,
    StNorm,
    StPos,
    StCorr,
    StOut
  } state_e;

endpackage
`default_nettype wire

### hw/rtl/lfpd_lane.sv
`default_nettype none
// One sensor lane: hold the running min/max and form the normalize operands.
module lfpd_lane #(
  parameter int unsigned AdcBits = lfpd_pkg::AdcBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cal_i,
  input  wire logic [AdcBits-1:0] sample_i,
  output logic signed [AdcBits+11:0] num_o,
  output logic signed [AdcBits+1:0]  den_o
);
  logic [AdcBits-1:0] min_q, max_q;
  logic signed [AdcBits+1:0] diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
      max_q <= '0;
    end else if (cal_i) begin
      if (sample_i > max_q) max_q <= sample_i;
      if (sample_i < min_q) min_q <= sample_i;
    end
  end

  assign diff  = $signed({2'b00, sample_i}) - $signed({2'b00, min_q});
  assign num_o = diff * $signed(12'sd1000);
  assign den_o = $signed({2'b00, max_q}) - $signed({2'b00, min_q});
endmodule
`default_nettype wire

### hw/rtl/lfpd_div.sv
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module lfpd_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [lfpd_pkg::DivW-1:0] num_i,
  input  wire logic signed [lfpd_pkg::DivW-1:0] den_i,
  output logic                              done_o,
  output logic signed [lfpd_pkg::DivW-1:0]  quo_o
);
  import lfpd_pkg::*;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] q_q, r_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic neg_q, busy_q, done_q;
  logic [DivW:0] trial;
  logic [DivW-1:0] rsh;

  assign rsh   = {r_q[DivW-2:0], q_q[DivW-1]};
  assign trial = {1'b0, rsh} - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i[DivW-1] ? DivW'(-num_i) : num_i;
      d_q   <= den_i[DivW-1] ? DivW'(-den_i) : den_i;
      r_q   <= '0;
      neg_q <= num_i[DivW-1] ^ den_i[DivW-1];
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        r_q <= trial[DivW-1:0];
        q_q <= {q_q[DivW-2:0], 1'b1};
      end else begin
        r_q <= rsh;
        q_q <= {q_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule
`default_nettype wire

### hw/rtl/line_follow_pd_steering.sv
`default_nettype none
// Flow: a calibrate word is absorbed at its accept edge. A run word passes through three
// normalizing divides and one centroid divide, then the error (StCorr) and then the
// correction/output (StOut), which waits while a held drive word is not yet taken.
// One word in flight: the next is accepted only once back in idle. All divides share the
// one-bit-per-cycle divider; a divide is skipped when a range is flat or the sum is not positive.
// Reset: min=all ones, max=0, previous error=0, gains/base to defaults, idle.
module line_follow_pd_steering #(
  parameter int unsigned AdcBits = lfpd_pkg::AdcBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: sample_left, sample_center, sample_right; tuser: op
  input  wire logic [((3*AdcBits+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: left_pwm, left_forward, right_pwm, right_forward, line_position
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [lfpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lfpd_pkg::CfgDataW-1:0] cfg_data_i
);
  import lfpd_pkg::*;
  localparam int unsigned NW = AdcBits + 12;

  logic [7:0] base_q;
  logic [9:0] kp_q, kd_q;
  state_e state_q, state_d;
  logic [1:0] lane_q;
  logic [AdcBits-1:0] smp_q [NumLanes];
  logic signed [NW-1:0] lnum [NumLanes];
  logic signed [AdcBits+1:0] lden [NumLanes];
  logic signed [DivW-1:0] n_q [NumLanes];
  logic signed [15:0] pos_q, prev_q, err_q;
  logic signed [DivW-1:0] div_num, div_den, quo;
  logic div_start, div_done, started_q;
  logic [39:0] out_q;
  logic ovalid_q;
  logic cal_w, acc, out_free;

  // Accept a new word whenever idle; a held drive word only blocks the next output.
  assign s_axis_tready = (state_q == StIdle);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign cal_w    = acc && (s_axis_tuser == OpCalibrate);
  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 8'd200;
      kp_q   <= 10'd102;
      kd_q   <= 10'd102;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBaseSpeed: base_q <= cfg_data_i[7:0];
        CfgKp:        kp_q   <= cfg_data_i;
        CfgKd:        kd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lfpd_lane #(.AdcBits(AdcBits)) u_lane (
      .clk_i, .rst_ni, .cal_i(cal_w),
      .sample_i(acc ? s_axis_tdata[g*AdcBits +: AdcBits] : smp_q[g]),
      .num_o(lnum[g]), .den_o(lden[g])
    );
  end

  // Merge: centroid numerator and sum of normalized values.
  logic signed [DivW-1:0] cnum, cden;
  assign cnum = n_q[1] * 48'sd1000 + n_q[2] * 48'sd2000;
  assign cden = n_q[0] + n_q[1] + n_q[2];

  // PD correction numerator (Q8), derivative on saturated errors.
  logic signed [17:0] derr;
  logic signed [DivW-1:0] pd;
  assign derr = 18'(err_q) - 18'(prev_q);
  assign pd = $signed({1'b0, kp_q}) * err_q + $signed({1'b0, kd_q}) * derr;

  always_comb begin
    div_num = '0;
    div_den = 48'sd1;
    case (state_q)
      StNorm: begin
        div_num = DivW'(lnum[lane_q]);
        div_den = DivW'(lden[lane_q]);
      end
      StPos:  begin div_num = cnum; div_den = cden; end
      default: ;
    endcase
  end

  assign div_start = !started_q &&
                     (state_q == StNorm || state_q == StPos) &&
                     !(state_q == StNorm && lden[lane_q] == '0) &&
                     !(state_q == StPos && (cden[DivW-1] || cden == '0));

  lfpd_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                  .den_i(div_den), .done_o(div_done), .quo_o(quo));

  function automatic logic signed [15:0] sat16(input logic signed [DivW-1:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Divide by 256 truncating toward zero: bias negative values before the shift.
  logic signed [DivW-1:0] pd_adj;
  assign pd_adj = pd + (pd[DivW-1] ? 48'sd255 : 48'sd0);

  logic signed [16:0] errw;
  logic signed [17:0] ld, rd, corr;
  logic [7:0] lm, rm;
  assign errw = 17'sd1000 - 17'(pos_q);
  assign corr = 18'(sat16(pd_adj >>> 8));
  assign ld = 18'($signed({1'b0, base_q})) - corr;
  assign rd = 18'($signed({1'b0, base_q})) + corr;
  assign lm = (ld > 18'sd255 || ld < -18'sd255) ? 8'd255 : (ld[17] ? 8'(-ld) : ld[7:0]);
  assign rm = (rd > 18'sd255 || rd < -18'sd255) ? 8'd255 : (rd[17] ? 8'(-rd) : rd[7:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc && s_axis_tuser == OpRun) state_d = StNorm;
      StNorm: if ((lden[lane_q] == '0 || div_done) && lane_q == 2'd2) state_d = StPos;
      StPos:  if (!div_start && (div_done || !started_q)) state_d = StCorr;
      StCorr: state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      lane_q    <= '0;
      started_q <= 1'b0;
      prev_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) started_q <= 1'b1;
      else if (div_done || state_d != state_q) started_q <= 1'b0;
      if (state_q == StNorm) begin
        if (lden[lane_q] == '0 || div_done) lane_q <= lane_q + 2'd1;
      end else begin
        lane_q <= '0;
      end
      // Hold the drive word until taken; load the next one once the slot frees.
      if (state_q == StOut && out_free) begin
        prev_q   <= err_q;
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int k = 0; k < NumLanes; k++) smp_q[k] <= s_axis_tdata[k*AdcBits +: AdcBits];
    end
    if (state_q == StNorm) begin
      if (lden[lane_q] == '0) n_q[lane_q] <= '0;
      else if (div_done) n_q[lane_q] <= quo;
    end
    if (state_q == StPos) begin
      if (div_done) pos_q <= sat16(quo);
      else if (!started_q && !div_start) pos_q <= 16'sd1000;
    end
    if (state_q == StCorr) begin
      err_q <= (errw > 17'sd32767) ? 16'sh7fff : errw[15:0];
    end
    if (state_q == StOut && out_free) begin
      out_q <= {6'b0, pos_q, (rd > 0) ? 1'b1 : 1'b0, rm, (ld > 0) ? 1'b1 : 1'b0, lm};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire
